FILE: rtl/core/sha1sh_pkg.sv
// shared types, constants and round functions for the sha-1 stream hasher
`default_nettype none

package sha1sh_pkg;

    localparam int CountWidth = 61;
    localparam int QueueDepth = 2;
    localparam int PtrWidth   = $clog2(QueueDepth);
    localparam int CntWidth   = $clog2(QueueDepth + 1);

    localparam logic [CountWidth-1:0] ByteLimit = '1;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [31:0] InitVector [0:4] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [7:0] PadByte     = 8'h80;
    localparam logic [5:0] LengthStart = 6'd56;
    localparam logic [5:0] LastSlot    = 6'd63;
    localparam logic [6:0] LastRound   = 7'd79;
    localparam logic [2:0] LastWord    = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ZERO,
        ST_LEN,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    // one classified input word on its way to the compression side
    typedef struct packed {
        logic [7:0]            data;
        logic                  byte_ok;
        logic                  is_end;
        logic                  ovf;
        logic [CountWidth-1:0] count;
    } entry_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        logic [63:0] dbl;
        dbl = {x, x} << n;
        return dbl[63:32];
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (t < 7'd20)
        begin
            f = (b & c) | (~b & d);
        end
        else if (t < 7'd40)
        begin
            f = b ^ c ^ d;
        end
        else if (t < 7'd60)
        begin
            f = (b & c) | (b & d) | (c & d);
        end
        else
        begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] t);
        logic [31:0] k;
        if (t < 7'd20)
        begin
            k = K0;
        end
        else if (t < 7'd40)
        begin
            k = K1;
        end
        else if (t < 7'd60)
        begin
            k = K2;
        end
        else
        begin
            k = K3;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sha1sh_front.sv
// input side: takes words, keeps the byte count and overflow flag, classifies
`default_nettype none

module sha1sh_front
    import sha1sh_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire logic   [7:0] in_byte,
    input  wire logic   in_has_byte,
    input  wire logic   in_end,
    input  wire logic   q_full,
    output logic        push,
    output entry_t      push_entry
);

    logic [CountWidth-1:0] count_reg, count_next;
    logic                  ovf_reg, ovf_next;
    logic                  take;
    logic                  at_limit;
    logic                  kept;
    logic                  dropped;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;
    assign at_limit = (count_reg == ByteLimit);
    assign kept     = in_has_byte && !at_limit;
    assign dropped  = in_has_byte && at_limit;

    always_comb
    begin
        push                = take && (in_has_byte || in_end);
        push_entry.data     = in_byte;
        push_entry.byte_ok  = kept;
        push_entry.is_end   = in_end;
        push_entry.ovf      = ovf_reg || dropped;
        push_entry.count    = count_reg + {{(CountWidth-1){1'b0}}, kept};
        count_next          = count_reg;
        ovf_next            = ovf_reg;
        if (take)
        begin
            if (in_end)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                count_next = push_entry.count;
                ovf_next   = push_entry.ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sha1sh_queue.sv
// short queue between the input side and the compression side
`default_nettype none

module sha1sh_queue
    import sha1sh_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t push_entry,
    output logic        full,
    input  wire logic   pop,
    output logic        head_valid,
    output entry_t      head
);

    entry_t                slot_reg [QueueDepth];
    logic [PtrWidth-1:0]   wr_reg, wr_next;
    logic [PtrWidth-1:0]   rd_reg, rd_next;
    logic [CntWidth-1:0]   cnt_reg, cnt_next;

    assign full       = (cnt_reg == CntWidth'(QueueDepth));
    assign head_valid = (cnt_reg != '0);
    assign head       = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PtrWidth'(QueueDepth - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == PtrWidth'(QueueDepth - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sha1sh_back.sv
// compression side: block packing, padding, 80-round compression, digest output
`default_nettype none

module sha1sh_back
    import sha1sh_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   head_valid,
    input  wire entry_t head,
    output logic        pop,
    output logic        out_valid,
    input  wire logic   out_ready,
    output logic [31:0] out_word,
    output logic [2:0]  out_number,
    output logic        out_last,
    output logic        out_flag
);

    state_t      state_reg, state_next;
    state_t      ret_reg, ret_next;
    logic [5:0]  fill_reg, fill_next;
    logic [6:0]  round_reg, round_next;
    logic [2:0]  widx_reg, widx_next;
    logic        ovf_reg, ovf_next;
    logic [63:0] len_reg, len_next;
    logic [31:0] blk_reg [16];
    logic [31:0] blk_next [16];
    logic [31:0] chain_reg [5];
    logic [31:0] chain_next [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] a_next, b_next, c_next, d_next, e_next;
    logic        ov_reg, ov_next;
    logic [31:0] ow_reg, ow_next;
    logic [2:0]  on_reg, on_next;
    logic        ol_reg, ol_next;
    logic        of_reg, of_next;

    logic        feed_en;
    logic [7:0]  feed_byte;
    state_t      after;
    logic [31:0] wt;
    logic [31:0] tmp;

    assign out_valid  = ov_reg;
    assign out_word   = ow_reg;
    assign out_number = on_reg;
    assign out_last   = ol_reg;
    assign out_flag   = of_reg;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        fill_next  = fill_reg;
        round_next = round_reg;
        widx_next  = widx_reg;
        ovf_next   = ovf_reg;
        len_next   = len_reg;
        blk_next   = blk_reg;
        chain_next = chain_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        ov_next    = ov_reg && !out_ready;
        ow_next    = ow_reg;
        on_next    = on_reg;
        ol_next    = ol_reg;
        of_next    = of_reg;
        pop        = 1'b0;
        feed_en    = 1'b0;
        feed_byte  = '0;
        after      = state_reg;
        wt         = (round_reg < 7'd16) ? blk_reg[0]
                   : rotl(blk_reg[13] ^ blk_reg[8] ^ blk_reg[2] ^ blk_reg[0], 1);
        tmp        = rotl(a_reg, 5) + round_f(round_reg, b_reg, c_reg, d_reg)
                   + e_reg + round_k(round_reg) + wt;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop       = 1'b1;
                    len_next  = {head.count, 3'b000};
                    ovf_next  = head.ovf;
                    feed_en   = head.byte_ok;
                    feed_byte = head.data;
                    after     = head.is_end ? ST_PAD : ST_IDLE;
                    state_next = after;
                end
            end
            ST_PAD:
            begin
                feed_en   = 1'b1;
                feed_byte = PadByte;
                after     = ST_ZERO;
            end
            ST_ZERO:
            begin
                if (fill_reg == LengthStart)
                begin
                    state_next = ST_LEN;
                end
                else
                begin
                    feed_en = 1'b1;
                    after   = ST_ZERO;
                end
            end
            ST_LEN:
            begin
                feed_en   = 1'b1;
                feed_byte = len_reg[63:56];
                len_next  = {len_reg[55:0], 8'h00};
                after     = (fill_reg == LastSlot) ? ST_OUT : ST_LEN;
            end
            ST_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    blk_next[i] = blk_reg[i+1];
                end
                blk_next[15] = wt;
                e_next       = d_reg;
                d_next       = c_reg;
                c_next       = rotl(b_reg, 30);
                b_next       = a_reg;
                a_next       = tmp;
                round_next   = round_reg + 1'b1;
                if (round_reg == LastRound)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                chain_next[4] = chain_reg[4] + e_reg;
                state_next    = ret_reg;
            end
            ST_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next   = 1'b1;
                    ow_next   = chain_reg[widx_reg];
                    on_next   = widx_reg;
                    ol_next   = (widx_reg == LastWord);
                    of_next   = ovf_reg;
                    widx_next = widx_reg + 1'b1;
                    if (widx_reg == LastWord)
                    begin
                        widx_next  = '0;
                        chain_next = InitVector;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // shift one byte into the block, start a compression when it fills
        if (feed_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                blk_next[i] = {blk_reg[i][23:0], blk_reg[i+1][31:24]};
            end
            blk_next[15] = {blk_reg[15][23:0], feed_byte};
            fill_next    = fill_reg + 1'b1;
            if (fill_reg == LastSlot)
            begin
                a_next     = chain_reg[0];
                b_next     = chain_reg[1];
                c_next     = chain_reg[2];
                d_next     = chain_reg[3];
                e_next     = chain_reg[4];
                round_next = '0;
                ret_next   = after;
                state_next = ST_ROUND;
            end
            else
            begin
                state_next = after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            fill_reg  <= '0;
            round_reg <= '0;
            widx_reg  <= '0;
            ovf_reg   <= 1'b0;
            chain_reg <= InitVector;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            fill_reg  <= fill_next;
            round_reg <= round_next;
            widx_reg  <= widx_next;
            ovf_reg   <= ovf_next;
            chain_reg <= chain_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        blk_reg <= blk_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
        ow_reg  <= ow_next;
        on_reg  <= on_next;
        ol_reg  <= ol_next;
        of_reg  <= of_next;
    end

    // compression only ever starts on a full block
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND |-> fill_reg == '0)
        else $error("compression running on a partial block");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LEN |-> fill_reg >= LengthStart)
        else $error("length bytes outside the last eight slots");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT |-> fill_reg == '0 && ret_reg == ST_OUT)
        else $error("digest output before final block was compressed");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ADD |-> $past(state_reg) == ST_ROUND && $past(round_reg) == LastRound)
        else $error("chain update without eighty rounds");

endmodule

`default_nettype wire

FILE: rtl/core/sha1_stream_hasher_core.sv
// top level of the byte-serial sha-1 stream hasher
`default_nettype none

// Byte-serial SHA-1 hasher. Each input word may carry one message byte
// (tuser set) and may end the message (tlast); after the last word the five
// digest words H0..H4 come out on the master side, the fifth with tlast, each
// with tuser set if the message passed 2^61-1 bytes. The input side takes one
// word per cycle while its two-entry queue has room. The compression side
// packs the bytes into 64-byte blocks and takes no byte while it compresses a
// full block (80 rounds of one shared round unit, then the chain add). Ending
// a message feeds the pad byte, zero bytes and the length bytes up to the
// block boundary, steps through the zero state without a byte before the
// length bytes, runs one or two compressions, and loads the digest words
// into the output register as the sink takes them; the last word then waits
// for the sink while new words are already taken.
module sha1_stream_hasher_core
    import sha1sh_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire logic   [7:0] s_axis_tdata,   // msg_byte
    input  wire logic   s_axis_tuser,         // has_byte
    input  wire logic   s_axis_tlast,         // end_of_message
    output logic        m_axis_tvalid,
    input  wire logic   m_axis_tready,
    output logic [39:0] m_axis_tdata,         // digest_word, word_number, zero fill
    output logic        m_axis_tuser,         // too_long
    output logic        m_axis_tlast          // last_word
);

    logic        q_full;
    logic        push;
    entry_t      push_entry;
    logic        pop;
    logic        head_valid;
    entry_t      head;
    logic [31:0] out_word;
    logic [2:0]  out_number;

    sha1sh_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_byte     (s_axis_tdata),
        .in_has_byte (s_axis_tuser),
        .in_end      (s_axis_tlast),
        .q_full      (q_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    sha1sh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    sha1sh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_word   (out_word),
        .out_number (out_number),
        .out_last   (m_axis_tlast),
        .out_flag   (m_axis_tuser)
    );

    assign m_axis_tdata = {5'b00000, out_number, out_word};

endmodule

`default_nettype wire

FILE: sim/sha1_digest_checker.sv
// digest predictor and scoreboard for the sha-1 stream hasher
`timescale 1ns / 100ps

module sha1_digest_checker
    import sha1sh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // msg_byte
    input  wire logic        s_axis_tuser,   // has_byte
    input  wire logic        s_axis_tlast,   // end_of_message
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [39:0] m_axis_tdata,   // digest_word, word_number, zero fill
    input  wire logic        m_axis_tuser,   // too_long
    input  wire logic        m_axis_tlast,   // last_word
    output int               pending,
    output int               errors
);

    typedef struct packed {
        logic [31:0] digest;
        logic [2:0]  index;
        logic        last;
        logic        too_long;
    } digest_word_t;

    digest_word_t digest_words_due [$];

    logic [31:0]           chain [5];
    logic [31:0]           blk [16];
    logic [CountWidth-1:0] msg_bytes;
    int unsigned           fill_level;
    logic                  length_overflow;

    function automatic logic [31:0] rotate_left(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic clear_hash();
        int i;
        for (i = 0; i < 5; i++)
        begin
            chain[i] = InitVector[i];
        end
        for (i = 0; i < 16; i++)
        begin
            blk[i] = '0;
        end
        msg_bytes       = '0;
        fill_level      = 0;
        length_overflow = 1'b0;
    endtask

    task automatic run_compression();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, wt, tmp;
        int t;
        for (t = 0; t < 16; t++)
        begin
            w[t] = blk[t];
        end
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (t = 0; t < 80; t++)
        begin
            if (t < 16)
            begin
                wt = w[t];
            end
            else
            begin
                wt = rotate_left(w[(t - 3) & 15] ^ w[(t - 8) & 15] ^
                                 w[(t - 14) & 15] ^ w[t & 15], 1);
                w[t & 15] = wt;
            end
            if (t < 20)
            begin
                f = (b & c) | (~b & d);
                k = K0;
            end
            else if (t < 40)
            begin
                f = b ^ c ^ d;
                k = K1;
            end
            else if (t < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K3;
            end
            tmp = rotate_left(a, 5) + f + e + k + wt;
            e = d;
            d = c;
            c = rotate_left(b, 30);
            b = a;
            a = tmp;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endtask

    task automatic place_block_byte(input logic [7:0] v);
        int unsigned pos;
        logic [31:0] bits;
        pos  = fill_level;
        bits = {24'd0, v} << ((3 - (pos & 3)) * 8);
        if ((pos & 3) == 0)
        begin
            blk[pos >> 2] = bits;
        end
        else
        begin
            blk[pos >> 2] |= bits;
        end
        fill_level = pos + 1;
        if (fill_level == 64)
        begin
            run_compression();
            fill_level = 0;
        end
    endtask

    task automatic absorb_word(input logic [7:0] data, input logic has_byte, input logic is_end);
        logic [63:0]  bit_length;
        digest_word_t dw;
        int i;
        if (has_byte)
        begin
            if (msg_bytes == ByteLimit)
            begin
                length_overflow = 1'b1;
            end
            else
            begin
                place_block_byte(data);
                msg_bytes++;
            end
        end
        if (is_end)
        begin
            place_block_byte(PadByte);
            while (fill_level > LengthStart)
            begin
                place_block_byte(8'h00);
            end
            while (fill_level < LengthStart)
            begin
                place_block_byte(8'h00);
            end
            bit_length = {msg_bytes, 3'b000};
            blk[14] = bit_length[63:32];
            blk[15] = bit_length[31:0];
            run_compression();
            for (i = 0; i < 5; i++)
            begin
                dw.digest   = chain[i];
                dw.index    = 3'(i);
                dw.last     = (3'(i) == LastWord);
                dw.too_long = length_overflow;
                digest_words_due.push_back(dw);
            end
            clear_hash();
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endtask

    task automatic check_digest_word();
        digest_word_t dw;
        if (digest_words_due.size() == 0)
        begin
            $error("digest word %h with none due", m_axis_tdata);
            errors++;
        end
        else
        begin
            dw = digest_words_due.pop_front();
            compare_field("digest_word", dw.digest, m_axis_tdata[31:0]);
            compare_field("word_number", {29'd0, dw.index}, {29'd0, m_axis_tdata[34:32]});
            compare_field("tdata_fill", 32'd0, {27'd0, m_axis_tdata[39:35]});
            compare_field("last_word", {31'd0, dw.last}, {31'd0, m_axis_tlast});
            compare_field("too_long", {31'd0, dw.too_long}, {31'd0, m_axis_tuser});
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            clear_hash();
            digest_words_due.delete();
            errors = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_digest_word();
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                absorb_word(s_axis_tdata, s_axis_tuser, s_axis_tlast);
            end
        end
        pending = digest_words_due.size();
    end

endmodule

FILE: sim/tb_sha1_stream_hasher_core.sv
// stimulus, sink and verdict for the sha-1 stream hasher core
`timescale 1ns / 100ps

module tb_sha1_stream_hasher_core;

    localparam int ItemTarget  = 410;
    localparam int HoldCycles  = 400;
    localparam int IdleLimit   = 5000;
    localparam int DrainCycles = 300;

    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_EVERY_FOURTH,
        SINK_MOSTLY
    } sink_mode_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // msg_byte
    logic        s_axis_tuser;    // has_byte
    logic        s_axis_tlast;    // end_of_message
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;    // digest_word, word_number, zero fill
    logic        m_axis_tuser;    // too_long
    logic        m_axis_tlast;    // last_word

    int         pending_words;
    int         fail_count;
    int         burst_left  = 0;
    int         items       = 0;
    int         idle_cycles = 0;
    int         sink_cycle  = 0;
    bit         hold_req    = 1'b0;
    sink_mode_t sink_mode   = SINK_OPEN;

    always #5 clk = ~clk;

    sha1_stream_hasher_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    sha1_digest_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .pending       (pending_words),
        .errors        (fail_count)
    );

    task automatic send_word(input logic [7:0] data, input logic has_byte, input logic is_end);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= has_byte;
        s_axis_tlast  <= is_end;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        burst_left--;
        if (has_byte || is_end)
        begin
            items++;
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        wait (pending_words == 0);
    endtask

    task automatic send_message(input int len);
        bit end_on_byte;
        int noise_pct;
        int i;
        end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        noise_pct   = ($urandom_range(0, 7) == 0) ? 25 : 0;
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(1, 100) <= noise_pct)
            begin
                send_word(8'($urandom), 1'b0, 1'b0);
            end
            send_word(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte)
        begin
            send_word(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    // sink side
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                sink_cycle++;
                if (sink_cycle % 96 == 0)
                begin
                    sink_mode = sink_mode_t'($urandom_range(0, 3));
                end
                case (sink_mode)
                    SINK_OPEN:         m_axis_tready <= 1'b1;
                    SINK_COIN:         m_axis_tready <= 1'($urandom_range(0, 1));
                    SINK_EVERY_FOURTH: m_axis_tready <= (sink_cycle % 4 == 0);
                    default:           m_axis_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IdleLimit)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int edge_lengths [12];
        int msg_no;
        int len;
        edge_lengths = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 0-3 byte messages, ignored words, end on a byte or alone
        send_word(8'hA5, 1'b0, 1'b1);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'hFF, 1'b1, 1'b1);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b1);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        send_word(8'h80, 1'b1, 1'b0);
        send_word(8'h7F, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h01, 1'b1, 1'b1);
        send_word(8'h5A, 1'b0, 1'b1);
        wait_drained();

        msg_no = 0;
        while (items < ItemTarget)
        begin
            if ($urandom_range(0, 9) < 3)
            begin
                len = edge_lengths[$urandom_range(0, 11)];
            end
            else
            begin
                len = $urandom_range(0, 70);
            end
            // sink holds off while the next messages keep coming
            if (msg_no == 3)
            begin
                hold_req = 1'b1;
                len = 20;
            end
            if (msg_no == 4)
            begin
                len = 100;
            end
            if (msg_no == 7)
            begin
                wait_drained();
            end
            send_message(len);
            msg_no++;
        end

        wait_drained();
        repeat (DrainCycles) @(posedge clk);
        if (fail_count == 0 && pending_words == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
